FILE: rtl/assert_macros.svh
// assertion macros for the rtl files that check themselves (ospf_neighbor_fsm_core)
// depends on nothing; each macro expects signals named clk and rst in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off while in reset
`define ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// next-cycle implication, off while in reset
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

FILE: rtl/onfsm_pkg.sv
// types, codes and helpers for the ospf neighbour state machine
// no dependencies; used by onfsm_step and ospf_neighbor_fsm_core
package onfsm_pkg;

  localparam int unsigned IdWidth    = 32;
  localparam int unsigned CmdWidth   = 4;
  localparam int unsigned InWidth    = 72;
  localparam int unsigned OutWidth   = 32;

  // neighbour states, one-hot
  typedef enum logic [6:0] {
    ST_DOWN     = 7'b0000001,
    ST_INIT     = 7'b0000010,
    ST_TWOWAY   = 7'b0000100,
    ST_EXSTART  = 7'b0001000,
    ST_EXCHANGE = 7'b0010000,
    ST_LOADING  = 7'b0100000,
    ST_FULL     = 7'b1000000
  } state_t;

  // state codes as seen on the result
  localparam logic [2:0] CODE_DOWN     = 3'd0;
  localparam logic [2:0] CODE_INIT     = 3'd1;
  localparam logic [2:0] CODE_TWOWAY   = 3'd2;
  localparam logic [2:0] CODE_EXSTART  = 3'd3;
  localparam logic [2:0] CODE_EXCHANGE = 3'd4;
  localparam logic [2:0] CODE_LOADING  = 3'd5;
  localparam logic [2:0] CODE_FULL     = 3'd6;

  // event codes
  typedef enum logic [3:0] {
    EV_HELLO       = 4'd0,
    EV_TWOWAY      = 4'd1,
    EV_NEGDONE     = 4'd2,
    EV_EXCHDONE    = 4'd3,
    EV_LOADDONE    = 4'd4,
    EV_ADJOK       = 4'd5,
    EV_SEQMISMATCH = 4'd6,
    EV_BADREQ      = 4'd7,
    EV_ONEWAY      = 4'd8,
    EV_INACTIVITY  = 4'd9
  } event_t;

  // interface roles
  localparam logic [1:0] ROLE_OTHER = 2'd0;

  // description exchange flags: master, more, init
  localparam logic [2:0] FL_MASTER = 3'b100;
  localparam logic [2:0] FL_MORE   = 3'b010;
  localparam logic [2:0] FL_INIT   = 3'b001;
  localparam logic [2:0] FL_START  = FL_MASTER | FL_MORE | FL_INIT;

  // one result item, last field in the lowest bits
  typedef struct packed {
    logic [15:0] change_count;
    logic [2:0]  dd_flags;
    logic        stop_dd_retrans;
    logic        clear_dr_bdr;
    logic        restart_inactivity;
    logic        clear_lsa_lists;
    logic        signal_neighbor_change;
    logic        send_lsreq;
    logic        send_dd;
    logic        full_transition;
    logic        state_changed;
    logic [2:0]  neighbor_state;
  } result_t;

  // one event as held in the input register
  typedef struct packed {
    event_t             cmd;
    logic [1:0]         iface_role;
    logic [IdWidth-1:0] dr_id;
    logic [IdWidth-1:0] bdr_id;
    logic               request_list_empty;
  } event_item_t;

  function automatic logic [2:0] state_code(input state_t s);
    logic [2:0] c;
    case (s)
      ST_DOWN:     c = CODE_DOWN;
      ST_INIT:     c = CODE_INIT;
      ST_TWOWAY:   c = CODE_TWOWAY;
      ST_EXSTART:  c = CODE_EXSTART;
      ST_EXCHANGE: c = CODE_EXCHANGE;
      ST_LOADING:  c = CODE_LOADING;
      ST_FULL:     c = CODE_FULL;
      default:     c = CODE_DOWN;
    endcase
    return c;
  endfunction

endpackage

FILE: rtl/onfsm_step.sv
// next-state and action logic for one neighbour event
// depends on onfsm_pkg
module onfsm_step (
  input  onfsm_pkg::event_item_t          item,
  input  onfsm_pkg::state_t               state,
  input  logic [2:0]                      flags,
  input  logic [15:0]                     count,
  input  logic [onfsm_pkg::IdWidth-1:0]   nbr_id,
  output onfsm_pkg::state_t               state_next,
  output logic [2:0]                      flags_next,
  output logic [15:0]                     count_next,
  output onfsm_pkg::result_t              res
);
  import onfsm_pkg::*;

  logic need;
  logic changed;
  logic at_most_init;
  logic from_exstart;
  logic from_exchange;
  logic send_dd, send_lsreq, nchg, clr, restart, clr_drbdr, stop_dd;

  assign need = (item.iface_role != ROLE_OTHER) ||
                (nbr_id == item.dr_id) || (nbr_id == item.bdr_id);

  assign at_most_init  = (state == ST_DOWN) || (state == ST_INIT);
  assign from_exchange = (state == ST_EXCHANGE) || (state == ST_LOADING) ||
                         (state == ST_FULL);
  assign from_exstart  = (state == ST_EXSTART) || from_exchange;

  always_comb begin
    state_next = state;
    flags_next = flags;
    send_dd    = 1'b0;
    send_lsreq = 1'b0;
    nchg       = 1'b0;
    clr        = 1'b0;
    restart    = 1'b0;
    clr_drbdr  = 1'b0;
    stop_dd    = 1'b0;
    case (item.cmd)
      EV_HELLO: begin
        restart = 1'b1;
        if (state == ST_DOWN) state_next = ST_INIT;
      end
      EV_TWOWAY: begin
        if (at_most_init) begin
          nchg = 1'b1;
          if (need) begin
            state_next = ST_EXSTART;
            flags_next = FL_START;
            send_dd    = 1'b1;
          end else begin
            state_next = ST_TWOWAY;
          end
        end
      end
      EV_NEGDONE: begin
        if (state == ST_EXSTART) begin
          state_next = ST_EXCHANGE;
          flags_next = flags & ~FL_INIT;
        end
      end
      EV_EXCHDONE: begin
        if (state == ST_EXCHANGE) begin
          stop_dd = 1'b1;
          if (item.request_list_empty) begin
            state_next = ST_FULL;
          end else begin
            state_next = ST_LOADING;
            send_lsreq = 1'b1;
          end
        end
      end
      EV_LOADDONE: begin
        if (state == ST_LOADING) state_next = ST_FULL;
      end
      EV_ADJOK: begin
        if (state == ST_TWOWAY) begin
          if (need) begin
            state_next = ST_EXSTART;
            flags_next = FL_START;
            send_dd    = 1'b1;
          end
        end else if (from_exstart && !need) begin
          state_next = ST_TWOWAY;
          clr        = 1'b1;
        end
      end
      EV_SEQMISMATCH, EV_BADREQ: begin
        if (from_exchange) begin
          state_next = ST_EXSTART;
          flags_next = FL_START;
          clr        = 1'b1;
          send_dd    = 1'b1;
        end
      end
      EV_ONEWAY: begin
        if (!at_most_init) begin
          state_next = ST_INIT;
          nchg       = 1'b1;
          clr        = 1'b1;
        end
      end
      EV_INACTIVITY: begin
        state_next = ST_DOWN;
        clr_drbdr  = 1'b1;
        clr        = 1'b1;
        nchg       = 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign changed    = (state_next != state);
  assign count_next = changed ? count + 16'd1 : count;

  always_comb begin
    res.neighbor_state         = state_code(state_next);
    res.state_changed          = changed;
    res.full_transition        = changed && ((state == ST_FULL) || (state_next == ST_FULL));
    res.send_dd                = send_dd;
    res.send_lsreq             = send_lsreq;
    res.signal_neighbor_change = nchg;
    res.clear_lsa_lists        = clr;
    res.restart_inactivity     = restart;
    res.clear_dr_bdr           = clr_drbdr;
    res.stop_dd_retrans        = stop_dd;
    res.dd_flags               = flags_next;
    res.change_count           = count_next;
  end

endmodule

FILE: rtl/ospf_neighbor_fsm_core.sv
// top level of the ospf neighbour state machine: input register, event logic, result register
// depends on onfsm_pkg, onfsm_step and assert_macros.svh
//
// channel   direction  tdata / payload                                 tuser
// s_axis    in         iface_role, dr_id, bdr_id, request_list_empty   cmd
// m_axis    out        result fields, see onfsm_pkg::result_t          -
// cfg       in         neighbor_router_id                              -
//
// one event per cycle sustained while m_axis is ready; an event's result reaches m_axis
// through the input register, then the result register written by onfsm_step
// the neighbour state, flags and change count update as the event moves into the
// result register, so back-to-back events see each other's state with no bubble
// rst (synchronous) sets Down, clears flags, count, router id and both valids
// a stalled m_axis holds the result and fills the input register, then s_axis stalls
`include "assert_macros.svh"

module ospf_neighbor_fsm_core (
  input  logic                          clk,
  input  logic                          rst,
  // input events
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // [1:0] iface_role, [33:2] dr_id, [65:34] bdr_id, [66] request_list_empty, rest zero
  input  logic [onfsm_pkg::InWidth-1:0] s_axis_tdata,
  // [3:0] cmd
  input  logic [onfsm_pkg::CmdWidth-1:0] s_axis_tuser,
  // results
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [2:0] neighbor_state, [3] state_changed, [4] full_transition, [5] send_dd,
  // [6] send_lsreq, [7] signal_neighbor_change, [8] clear_lsa_lists,
  // [9] restart_inactivity, [10] clear_dr_bdr, [11] stop_dd_retrans,
  // [14:12] dd_flags, [30:15] change_count, [31] zero
  output logic [onfsm_pkg::OutWidth-1:0] m_axis_tdata,
  // neighbour router id register
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [onfsm_pkg::IdWidth-1:0] cfg_data
);
  import onfsm_pkg::*;

  // configuration
  logic [IdWidth-1:0] nbr_id;

  // input register
  logic        in_valid;
  event_item_t in_item;

  // neighbour context
  state_t      state;
  state_t      state_next;
  logic [2:0]  flags;
  logic [2:0]  flags_next;
  logic [15:0] count;
  logic [15:0] count_next;

  // result register
  logic    out_valid;
  result_t out_res;
  result_t res_next;

  logic adv;       // result register may take a new item this cycle
  logic fire;      // event moves from input register into result register
  logic in_take;   // s_axis transfer

  assign cfg_ready = 1'b1;

  assign adv           = !out_valid || m_axis_tready;
  assign fire          = in_valid && adv;
  assign s_axis_tready = !in_valid || adv;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  // register write, taken whenever offered
  always_ff @(posedge clk) begin
    if (rst) begin
      nbr_id <= '0;
    end else if (cfg_valid) begin
      nbr_id <= cfg_data;
    end
  end

  // input register: refilled as it empties
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_item.cmd                <= event_t'(s_axis_tuser);
      in_item.iface_role         <= s_axis_tdata[1:0];
      in_item.dr_id              <= s_axis_tdata[33:2];
      in_item.bdr_id             <= s_axis_tdata[65:34];
      in_item.request_list_empty <= s_axis_tdata[66];
    end
  end

  onfsm_step u_step (
    .item       (in_item),
    .state      (state),
    .flags      (flags),
    .count      (count),
    .nbr_id     (nbr_id),
    .state_next (state_next),
    .flags_next (flags_next),
    .count_next (count_next),
    .res        (res_next)
  );

  // neighbour context commits with the event
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_DOWN;
      flags <= '0;
      count <= '0;
    end else if (fire) begin
      state <= state_next;
      flags <= flags_next;
      count <= count_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_res <= res_next;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {1'b0, out_res};

  // checks
  // state register stays one-hot
  `ASSERT_IMPL(a_state_onehot, 1'b1, $onehot(state))
  // a moving event always lands in the result register
  `ASSERT_NEXT(a_fire_fills, fire, out_valid)
  // the change count steps by exactly one on a state change
  `ASSERT_NEXT(a_count_step, fire && res_next.state_changed, count == $past(count) + 16'd1)
  // a full transition is always a state change
  `ASSERT_IMPL(a_full_is_change, out_valid && out_res.full_transition, out_res.state_changed)

endmodule
